>>> design/pmtg_pkg.sv
// ----------------------------------------------------------------------------
// pmtg_pkg
// Mode, kind and error codes, payload types and the mode tables of the
// process mode transition guard.
// ----------------------------------------------------------------------------
package pmtg_pkg;

   // Fine process modes
   localparam logic [3:0] MODE_IDLE          = 4'd0;
   localparam logic [3:0] MODE_INJECT_PREP   = 4'd1;
   localparam logic [3:0] MODE_INJECT_RUN    = 4'd2;
   localparam logic [3:0] MODE_INJECT_STAB   = 4'd3;
   localparam logic [3:0] MODE_DRAIN_PREP    = 4'd4;
   localparam logic [3:0] MODE_DRAIN_RUN     = 4'd5;
   localparam logic [3:0] MODE_CLEAN_PREP    = 4'd6;
   localparam logic [3:0] MODE_CLEAN_FILL    = 4'd7;
   localparam logic [3:0] MODE_CLEAN_DRAIN   = 4'd8;
   localparam logic [3:0] MODE_SAMPLE_PREP   = 4'd9;
   localparam logic [3:0] MODE_SAMPLE_ACQ    = 4'd10;
   localparam logic [3:0] MODE_ERROR         = 4'd11;
   localparam logic [3:0] MODE_ESTOP         = 4'd12;
   localparam int         MODE_COUNT         = 13;

   // Coarse modes
   localparam logic [2:0] COARSE_INITIAL = 3'd0;
   localparam logic [2:0] COARSE_INJECT  = 3'd1;
   localparam logic [2:0] COARSE_DRAIN   = 3'd2;
   localparam logic [2:0] COARSE_CLEAN   = 3'd3;
   localparam logic [2:0] COARSE_SAMPLE  = 3'd4;

   // Event kinds
   localparam logic [2:0] KIND_GUARDED = 3'd0;
   localparam logic [2:0] KIND_FORCED  = 3'd1;
   localparam logic [2:0] KIND_ESTOP   = 3'd2;
   localparam logic [2:0] KIND_RECOVER = 3'd3;
   localparam logic [2:0] KIND_SYNC    = 3'd4;

   // Error codes
   localparam logic [1:0] ERR_NONE        = 2'd0;
   localparam logic [1:0] ERR_ILLEGAL     = 2'd1;
   localparam logic [1:0] ERR_NOT_FAULTED = 2'd2;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] target_mode;
      logic [2:0] coarse_mode_in;
   } req_type;

   typedef struct packed {
      logic                  accepted;
      logic [1:0]            error_code;
      logic [3:0]            previous_mode;
      logic [3:0]            present_mode;
      logic                  change_notice;
      logic                  coarse_cmd_valid;
      logic [2:0]            coarse_cmd;
      logic [MODE_COUNT-1:0] legal_next_mask;
   } rsp_type;

   // Escape set: idle, error and emergency stop
   localparam logic [MODE_COUNT-1:0] ESC_SET = 13'b1_1000_0000_0001;

   // Legal guarded targets from a given mode
   function automatic logic [MODE_COUNT-1:0] legal_mask(input logic [3:0] mode);
      logic [MODE_COUNT-1:0] m;
      unique case (mode)
         MODE_IDLE:        m = 13'b1_1010_0101_0010;
         MODE_INJECT_PREP: m = ESC_SET | 13'b0_0000_0000_0100;
         MODE_INJECT_RUN:  m = ESC_SET | 13'b0_0000_0000_1000;
         MODE_INJECT_STAB: m = ESC_SET;
         MODE_DRAIN_PREP:  m = ESC_SET | 13'b0_0000_0010_0000;
         MODE_DRAIN_RUN:   m = ESC_SET;
         MODE_CLEAN_PREP:  m = ESC_SET | 13'b0_0000_1000_0000;
         MODE_CLEAN_FILL:  m = ESC_SET | 13'b0_0001_0000_0000;
         MODE_CLEAN_DRAIN: m = ESC_SET | 13'b0_0000_1000_0000;
         MODE_SAMPLE_PREP: m = ESC_SET | 13'b0_0100_0000_0000;
         MODE_SAMPLE_ACQ:  m = ESC_SET;
         MODE_ERROR:       m = 13'b0_0000_0000_0001;
         MODE_ESTOP:       m = 13'b0_0000_0000_0001;
         default:          m = '0;
      endcase
      return m;
   endfunction

   // Coarse mode that a fine mode belongs to
   function automatic logic [2:0] coarse_of(input logic [3:0] mode);
      logic [2:0] c;
      unique case (mode)
         MODE_INJECT_PREP, MODE_INJECT_RUN, MODE_INJECT_STAB: c = COARSE_INJECT;
         MODE_DRAIN_PREP, MODE_DRAIN_RUN:                     c = COARSE_DRAIN;
         MODE_CLEAN_PREP, MODE_CLEAN_FILL, MODE_CLEAN_DRAIN:  c = COARSE_CLEAN;
         MODE_SAMPLE_PREP, MODE_SAMPLE_ACQ:                   c = COARSE_SAMPLE;
         default:                                             c = COARSE_INITIAL;
      endcase
      return c;
   endfunction

   // Fine mode entered when the outside coarse mode changes
   function automatic logic [3:0] fine_of(input logic [2:0] coarse);
      logic [3:0] f;
      unique case (coarse)
         COARSE_INJECT: f = MODE_INJECT_RUN;
         COARSE_DRAIN:  f = MODE_DRAIN_RUN;
         COARSE_CLEAN:  f = MODE_CLEAN_FILL;
         COARSE_SAMPLE: f = MODE_SAMPLE_ACQ;
         default:       f = MODE_IDLE;
      endcase
      return f;
   endfunction

endpackage

>>> design/pmtg_if.sv
// ----------------------------------------------------------------------------
// pmtg channel interfaces
// Request, response and control register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface pmtg_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [3:0] target_mode;
   logic [2:0] coarse_mode_in;

   modport source (output valid, kind, target_mode, coarse_mode_in, input ready);
   modport sink   (input valid, kind, target_mode, coarse_mode_in, output ready);
endinterface

interface pmtg_rsp_if;
   logic        valid;
   logic        ready;
   logic        accepted;
   logic [1:0]  error_code;
   logic [3:0]  previous_mode;
   logic [3:0]  present_mode;
   logic        change_notice;
   logic        coarse_cmd_valid;
   logic [2:0]  coarse_cmd;
   logic [12:0] legal_next_mask;

   modport source (output valid, accepted, error_code, previous_mode, present_mode,
                   change_notice, coarse_cmd_valid, coarse_cmd, legal_next_mask,
                   input ready);
   modport sink   (input valid, accepted, error_code, previous_mode, present_mode,
                   change_notice, coarse_cmd_valid, coarse_cmd, legal_next_mask,
                   output ready);
   modport monitor (input valid, ready, accepted, error_code, previous_mode,
                    present_mode, change_notice, coarse_cmd_valid, coarse_cmd,
                    legal_next_mask);
endinterface

interface pmtg_csr_if;
   logic valid;
   logic ready;
   logic coarse_link_enabled;

   modport source (output valid, coarse_link_enabled, input ready);
   modport sink   (input valid, coarse_link_enabled, output ready);
endinterface

>>> design/pmtg_eval.sv
// ----------------------------------------------------------------------------
// pmtg_eval
// Decide one request against the held fine mode and build its response.
// ----------------------------------------------------------------------------
module pmtg_eval (
   input  pmtg_pkg::req_type req,
   input  logic [3:0]        mode,
   input  logic              link_enabled,
   output pmtg_pkg::rsp_type rsp
);

   logic       acc;
   logic [1:0] err;
   logic [3:0] next_mode;
   logic       notice;
   logic       drive;
   logic [3:0] tgt;
   logic       tgt_ok;
   logic [2:0] cin;
   logic [pmtg_pkg::MODE_COUNT-1:0] cur_mask;

   // Emergency stop ignores the target field
   assign tgt      = (req.kind == pmtg_pkg::KIND_ESTOP) ? pmtg_pkg::MODE_ESTOP
                                                        : req.target_mode;
   assign tgt_ok   = (tgt <= pmtg_pkg::MODE_ESTOP);
   assign cin      = (req.coarse_mode_in > pmtg_pkg::COARSE_SAMPLE)
                   ? pmtg_pkg::COARSE_INITIAL : req.coarse_mode_in;
   assign cur_mask = pmtg_pkg::legal_mask(mode);

   always_comb begin
      acc       = 1'b1;
      err       = pmtg_pkg::ERR_NONE;
      next_mode = mode;
      notice    = 1'b0;
      drive     = 1'b0;
      unique case (req.kind) inside
         pmtg_pkg::KIND_GUARDED: begin
            if (!tgt_ok) begin
               acc = 1'b0;
               err = pmtg_pkg::ERR_ILLEGAL;
            end else if (tgt != mode) begin
               if (cur_mask[tgt]) begin
                  next_mode = tgt;
                  notice    = 1'b1;
                  drive     = 1'b1;
               end else begin
                  acc = 1'b0;
                  err = pmtg_pkg::ERR_ILLEGAL;
               end
            end
         end
         pmtg_pkg::KIND_FORCED, pmtg_pkg::KIND_ESTOP: begin
            if (!tgt_ok) begin
               acc = 1'b0;
               err = pmtg_pkg::ERR_ILLEGAL;
            end else begin
               next_mode = tgt;
               notice    = 1'b1;
               drive     = 1'b1;
            end
         end
         pmtg_pkg::KIND_RECOVER: begin
            if (mode == pmtg_pkg::MODE_ERROR || mode == pmtg_pkg::MODE_ESTOP) begin
               next_mode = pmtg_pkg::MODE_IDLE;
               notice    = 1'b1;
               drive     = 1'b1;
            end else begin
               acc = 1'b0;
               err = pmtg_pkg::ERR_NOT_FAULTED;
            end
         end
         pmtg_pkg::KIND_SYNC: begin
            if (pmtg_pkg::coarse_of(mode) != cin) begin
               next_mode = pmtg_pkg::fine_of(cin);
               notice    = 1'b1;
            end
         end
         default: begin
            acc = 1'b0;
            err = pmtg_pkg::ERR_ILLEGAL;
         end
      endcase
   end

   always_comb begin
      rsp                  = '0;
      rsp.accepted         = acc;
      rsp.error_code       = err;
      rsp.previous_mode    = mode;
      rsp.present_mode     = next_mode;
      rsp.change_notice    = notice;
      rsp.coarse_cmd_valid = drive & link_enabled;
      rsp.coarse_cmd       = (drive & link_enabled) ? pmtg_pkg::coarse_of(next_mode)
                                                    : pmtg_pkg::COARSE_INITIAL;
      rsp.legal_next_mask  = pmtg_pkg::legal_mask(next_mode);
   end

endmodule

>>> design/process_mode_transition_guard_core.sv
// ----------------------------------------------------------------------------
// process_mode_transition_guard_core
// Holds the fine process mode and answers each mode request with one
// response carrying the outcome, both modes, notices and the legal mask.
// ----------------------------------------------------------------------------
//
//   channel | dir | modport | carries
//   --------+-----+---------+------------------------------------------------
//   req_ch  | in  | sink    | kind, target_mode, coarse_mode_in
//   rsp_ch  | out | source  | outcome, modes, notice, coarse command, mask
//   csr_ch  | in  | sink    | coarse_link_enabled write
//
// A request is registered on acceptance, evaluated against the held mode and
// written into the response register together with the new mode when it
// advances; one request per cycle is sustained while rsp_ch is ready. The
// held mode register is the only loop; each evaluation sees the mode left by
// the previous request. Reset returns the mode to idle, enables the coarse
// link and empties both stages. A stalled response holds its register and
// backs pressure into the input stage, then to req_ch.
// ----------------------------------------------------------------------------
module process_mode_transition_guard_core (
   input  logic       clock,
   input  logic       reset,
   pmtg_req_if.sink   req_ch,
   pmtg_rsp_if.source rsp_ch,
   pmtg_csr_if.sink   csr_ch
);

   // Input stage
   logic              in_valid_ff;
   logic              in_valid_in;
   pmtg_pkg::req_type in_data_ff;

   // Held state
   logic [3:0] fine_mode_ff;
   logic [3:0] fine_mode_in;
   logic       link_ff;
   logic       link_in;

   // Response stage
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   pmtg_pkg::rsp_type rsp_data_ff;
   pmtg_pkg::rsp_type eval_rsp;

   logic advance;
   logic req_take;

   // Advance the input stage whenever the response register is free or drains
   assign advance  = in_valid_ff & (~rsp_valid_ff | rsp_ch.ready);
   assign req_take = req_ch.valid & req_ch.ready;

   assign req_ch.ready = ~in_valid_ff | advance;
   assign csr_ch.ready = 1'b1;

   pmtg_eval u_eval (
      .req          (in_data_ff),
      .mode         (fine_mode_ff),
      .link_enabled (link_ff),
      .rsp          (eval_rsp)
   );

   always_comb begin
      in_valid_in  = req_take | (in_valid_ff & ~advance);
      rsp_valid_in = advance | (rsp_valid_ff & ~rsp_ch.ready);
      // Commit the new mode only when the request moves into the response
      fine_mode_in = advance ? eval_rsp.present_mode : fine_mode_ff;
      link_in      = (csr_ch.valid & csr_ch.ready) ? csr_ch.coarse_link_enabled : link_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fine_mode_ff <= pmtg_pkg::MODE_IDLE;
         link_ff      <= 1'b1;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fine_mode_ff <= fine_mode_in;
         link_ff      <= link_in;
      end
   end

   // Payload registers: input loads on acceptance, response on advance; hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff.kind           <= req_ch.kind;
         in_data_ff.target_mode    <= req_ch.target_mode;
         in_data_ff.coarse_mode_in <= req_ch.coarse_mode_in;
      end
      if (advance) begin
         rsp_data_ff <= eval_rsp;
      end
   end

   // Drive the response channel straight from its register
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.accepted         = rsp_data_ff.accepted;
   assign rsp_ch.error_code       = rsp_data_ff.error_code;
   assign rsp_ch.previous_mode    = rsp_data_ff.previous_mode;
   assign rsp_ch.present_mode     = rsp_data_ff.present_mode;
   assign rsp_ch.change_notice    = rsp_data_ff.change_notice;
   assign rsp_ch.coarse_cmd_valid = rsp_data_ff.coarse_cmd_valid;
   assign rsp_ch.coarse_cmd       = rsp_data_ff.coarse_cmd;
   assign rsp_ch.legal_next_mask  = rsp_data_ff.legal_next_mask;

endmodule

>>> design/pmtg_checker.sv
// ----------------------------------------------------------------------------
// pmtg_checker
// Port-level checks on the response stream of the mode guard.
// ----------------------------------------------------------------------------
module pmtg_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [3:0] rsp_previous_mode,
   input logic [3:0] rsp_present_mode
);

   // Track the mode reported by the last delivered response
   logic [3:0] last_mode_ff;
   logic [3:0] last_mode_in;

   assign last_mode_in = (rsp_valid & rsp_ready) ? rsp_present_mode : last_mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_mode_ff <= pmtg_pkg::MODE_IDLE;
      end else begin
         last_mode_ff <= last_mode_in;
      end
   end

   // Each response starts from the mode the previous one left
   a_mode_chain: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_previous_mode == last_mode_ff)
      else $error("response previous_mode breaks the mode chain");

   // Reset empties the response register
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_present_mode) && $stable(rsp_previous_mode))
      else $error("stalled response changed");

endmodule

bind process_mode_transition_guard_core pmtg_checker u_pmtg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_previous_mode (rsp_ch.previous_mode),
   .rsp_present_mode  (rsp_ch.present_mode)
);
